@@ hdl/ppru_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the pixel replication upscaler.
// No dependencies; imported by every module of the block but ppru_ram.
package ppru_pkg;

    localparam int ROW_WIDTH_W  = 12;
    localparam int SCALE_W      = 4;
    localparam int CFG_DATA_W   = 12;
    localparam int CFG_INDEX_W  = 1;
    localparam int PIX_W        = 24;
    localparam int CNT_W        = 7;   // holds the largest supported scale
    localparam int QUEUE_DEPTH  = 4;

    localparam int DEF_MAX_WIDTH = 2048;
    localparam int DEF_MAX_SCALE = 10;

    localparam logic [CFG_INDEX_W-1:0] REG_ROW_WIDTH = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_SCALE     = 1'b1;

    localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RESET = 12'd640;
    localparam logic [SCALE_W-1:0]     SCALE_RESET     = 4'd1;

    localparam logic REQ_PIXEL  = 1'b0;
    localparam logic REQ_REPLAY = 1'b1;

    typedef struct packed {
        logic       req_type;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } request_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       last_copy;
        logic       row_end;
    } result_t;

    // One classified item handed from the front end to the back end
    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic             at_end;
        logic [CNT_W-1:0] copies;
    } cmd_t;

endpackage

@@ hdl/ppru_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ppru_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/ppru_queue.sv @@
`timescale 1ns / 1ps
// Short flip-flop queue of commands between the front and back ends.
// Depends on ppru_pkg for cmd_t.
module ppru_queue
    import ppru_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr,
    input  cmd_t                       wdata,
    input  logic                       rd,
    output cmd_t                       rdata,
    output logic                       not_empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          entry_reg [DEPTH];
    logic [PW-1:0] wptr_reg, wptr_next;
    logic [PW-1:0] rptr_reg, rptr_next;
    logic [CW-1:0] count_reg, count_next;

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (wr)
        begin
            wptr_next = (int'(wptr_reg) == DEPTH - 1) ? '0 : wptr_reg + PW'(1);
        end
        if (rd)
        begin
            rptr_next = (int'(rptr_reg) == DEPTH - 1) ? '0 : rptr_reg + PW'(1);
        end
        if (wr && !rd)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (rd && !wr)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            entry_reg[wptr_reg] <= wdata;
        end
    end

    assign rdata     = entry_reg[rptr_reg];
    assign not_empty = (count_reg != '0);
    assign count     = count_reg;

endmodule

@@ hdl/ppru_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts requests, tracks write and replay columns, owns the
// line buffer and hands classified commands to the queue. Uses ppru_pkg, ppru_ram.
module ppru_front
    import ppru_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    parameter int MAX_SCALE = DEF_MAX_SCALE
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    output logic                               full,
    input  request_t                           request,
    input  logic [ROW_WIDTH_W-1:0]             row_width,
    input  logic [SCALE_W-1:0]                 scale,
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0]   q_count,
    output logic                               q_wr,
    output cmd_t                               q_cmd
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int EW    = ((COL_W > ROW_WIDTH_W) ? COL_W : ROW_WIDTH_W) + 1;
    localparam int QCW   = $clog2(QUEUE_DEPTH + 1);

    logic [COL_W-1:0] wcol_reg, wcol_next;
    logic [COL_W-1:0] rcol_reg, rcol_next;
    logic             s1_valid_reg, s1_valid_next;
    logic             s1_replay_reg;
    logic [PIX_W-1:0] s1_pix_reg;
    logic             s1_end_reg;
    logic [CNT_W-1:0] s1_cnt_reg;

    logic             accept;
    logic             is_replay;
    logic [COL_W-1:0] wcol, rcol, col, col_inc;
    logic [EW-1:0]    width_eff;
    logic             at_end;
    logic [CNT_W-1:0] copies;
    logic [PIX_W-1:0] pix_in;
    logic [PIX_W-1:0] ram_rdata;

    // Room is needed for the item in flight as well as the new one
    assign full   = (QCW'(q_count) + QCW'(s1_valid_reg)) >= QCW'(QUEUE_DEPTH);
    assign accept = push && !full;

    assign is_replay = (request.req_type == REQ_REPLAY);
    assign pix_in    = {request.red_in, request.green_in, request.blue_in};

    always_comb
    begin
        wcol = (int'(wcol_reg) < MAX_WIDTH) ? wcol_reg : '0;
        rcol = (int'(rcol_reg) < MAX_WIDTH) ? rcol_reg : '0;
        col  = is_replay ? rcol : wcol;
        col_inc = col + COL_W'(1);

        width_eff = EW'(row_width);
        if (width_eff == '0)
        begin
            width_eff = EW'(1);
        end
        else if (width_eff > EW'(MAX_WIDTH))
        begin
            width_eff = EW'(MAX_WIDTH);
        end
        at_end = (EW'(col) + EW'(1)) >= width_eff;

        copies = (CNT_W'(scale) > CNT_W'(MAX_SCALE)) ? CNT_W'(MAX_SCALE) : CNT_W'(scale);
    end

    always_comb
    begin
        wcol_next     = wcol_reg;
        rcol_next     = rcol_reg;
        s1_valid_next = 1'b0;
        if (accept)
        begin
            s1_valid_next = (copies != '0);
            if (is_replay)
            begin
                rcol_next = at_end ? '0 : col_inc;
            end
            else if (at_end)
            begin
                // row complete: restart both columns
                wcol_next = '0;
                rcol_next = '0;
            end
            else
            begin
                wcol_next = col_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wcol_reg     <= '0;
            rcol_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            wcol_reg     <= wcol_next;
            rcol_reg     <= rcol_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_replay_reg <= is_replay;
            s1_pix_reg    <= pix_in;
            s1_end_reg    <= at_end;
            s1_cnt_reg    <= copies;
        end
    end

    ppru_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk   (clk),
        .we    (accept && !is_replay),
        .waddr (wcol),
        .wdata (pix_in),
        .re    (accept && is_replay),
        .raddr (rcol),
        .rdata (ram_rdata)
    );

    assign q_wr         = s1_valid_reg;
    assign q_cmd.pix    = s1_replay_reg ? ram_rdata : s1_pix_reg;
    assign q_cmd.at_end = s1_end_reg;
    assign q_cmd.copies = s1_cnt_reg;

endmodule

@@ hdl/ppru_back.sv @@
`timescale 1ns / 1ps
// Back end: expands each command into its copies, one per cycle while the output
// register can take one; the result side reads that register. Uses ppru_pkg.
module ppru_back
    import ppru_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cmd_valid,
    input  cmd_t    cmd,
    output logic    cmd_rd,
    output logic    empty,
    input  logic    pop,
    output result_t result
);

    logic             cur_valid_reg, cur_valid_next;
    logic [CNT_W-1:0] left_reg, left_next;
    cmd_t             cur_reg;
    logic             out_valid_reg, out_valid_next;
    result_t          out_reg;

    logic out_free, emit, last, load;

    assign out_free = !out_valid_reg || pop;
    assign emit     = out_free && cur_valid_reg;
    assign last     = (left_reg == CNT_W'(1));
    assign load     = !cur_valid_reg || (emit && last);
    assign cmd_rd   = load && cmd_valid;

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        left_next      = left_reg;
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd_rd)
        begin
            cur_valid_next = 1'b1;
            left_next      = cmd.copies;
        end
        else if (emit)
        begin
            if (last)
            begin
                cur_valid_next = 1'b0;
            end
            else
            begin
                left_next = left_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            left_reg      <= left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_rd)
        begin
            cur_reg <= cmd;
        end
        if (emit)
        begin
            out_reg.red_out   <= cur_reg.pix[23:16];
            out_reg.green_out <= cur_reg.pix[15:8];
            out_reg.blue_out  <= cur_reg.pix[7:0];
            out_reg.last_copy <= last;
            out_reg.row_end   <= last && cur_reg.at_end;
        end
    end

    assign empty  = !out_valid_reg;
    assign result = out_reg;

endmodule

@@ hdl/pixel_replication_upscaler.sv @@
`timescale 1ns / 1ps
// Integer nearest-neighbour upscaler. A new pixel is stored in the line buffer
// at the write column and given out scale times; a replay request reads the
// next stored pixel of the row and gives it out scale times. Scale above
// MAX_SCALE saturates, scale zero gives nothing but still advances columns.
// Requests are taken one per cycle until the four-entry command queue fills;
// the output side moves one pixel per cycle while results are popped, and an
// item holds the back end until all its copies (saturated) are out, which sets
// the sustained rate. The line buffer needs no clearing.
// Configure only while idle. Uses ppru_pkg, ppru_front, ppru_queue, ppru_back.
module pixel_replication_upscaler
    import ppru_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    parameter int MAX_SCALE = DEF_MAX_SCALE
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  request_t               request,
    output logic                   empty,
    input  logic                   pop,
    output result_t                result,
    input  logic                   wr_en,
    input  logic [CFG_INDEX_W-1:0] wr_index,
    input  logic [CFG_DATA_W-1:0]  wr_data
);

    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    logic [ROW_WIDTH_W-1:0] row_width_reg, row_width_next;
    logic [SCALE_W-1:0]     scale_reg, scale_next;

    logic           q_wr, q_rd, q_not_empty;
    cmd_t           q_wcmd, q_rcmd;
    logic [QCW-1:0] q_count;

    always_comb
    begin
        row_width_next = row_width_reg;
        scale_next     = scale_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_ROW_WIDTH: row_width_next = wr_data[ROW_WIDTH_W-1:0];
                REG_SCALE:     scale_next     = wr_data[SCALE_W-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg <= ROW_WIDTH_RESET;
            scale_reg     <= SCALE_RESET;
        end
        else
        begin
            row_width_reg <= row_width_next;
            scale_reg     <= scale_next;
        end
    end

    ppru_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_SCALE (MAX_SCALE)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .request   (request),
        .row_width (row_width_reg),
        .scale     (scale_reg),
        .q_count   (q_count),
        .q_wr      (q_wr),
        .q_cmd     (q_wcmd)
    );

    ppru_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (q_wr),
        .wdata     (q_wcmd),
        .rd        (q_rd),
        .rdata     (q_rcmd),
        .not_empty (q_not_empty),
        .count     (q_count)
    );

    ppru_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_not_empty),
        .cmd       (q_rcmd),
        .cmd_rd    (q_rd),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

    // Queue must never be written when it holds no room
    assert property (@(posedge clk) disable iff (!rst_n)
        q_wr |-> (q_count < QCW'(QUEUE_DEPTH)) || q_rd)
        else $error("command queue overflow");

    // Back end reads only what is there
    assert property (@(posedge clk) disable iff (!rst_n)
        q_rd |-> q_not_empty)
        else $error("command queue underflow");

    // Row end only on the final copy of an item
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty && result.row_end |-> result.last_copy)
        else $error("row_end without last_copy");

    // An empty queue leaves room for a request
    assert property (@(posedge clk) disable iff (!rst_n)
        q_count == '0 |-> !full)
        else $error("full asserted with empty queue");

endmodule
